/* rtl/shelf_rect_packer_top_macros.svh */
// Assertion macros shared by the shelf packer checker.
`ifndef SHELF_RECT_PACKER_TOP_MACROS_SVH
`define SHELF_RECT_PACKER_TOP_MACROS_SVH

// Implication in the same cycle, sampled on aclk and disabled during reset.
`define SRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the following cycle, sampled on aclk and disabled during reset.
`define SRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srp_pkg.sv */
// Package with the codes, widths and helper function of the shelf rectangle packer.
package srp_pkg;

    localparam int unsigned FIELD_W                  = 12;
    localparam int unsigned POS_W                    = 11;
    localparam int unsigned CFG_INDEX_W              = 4;
    localparam int unsigned MAX_ATLAS_HEIGHT_DEFAULT = 2048;

    localparam logic [FIELD_W-1:0] ATLAS_WIDTH_LIMIT = 12'd2048;
    localparam logic [FIELD_W-1:0] USED_SIZE_CLAMP   = 12'hFFF;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_PLACE  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] FM_RGBA  = 2'd0;
    localparam logic [1:0] FM_RGB   = 2'd1;
    localparam logic [1:0] FM_ALPHA = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam logic PM_FLAT  = 1'b0;
    localparam logic PM_SPLIT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ATLAS_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKING_MODE = 4'd1;

    // Smallest power of two, at least one, not below v; v must not exceed 2048.
    function automatic logic [FIELD_W-1:0] pow2_ceil(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] m;
        logic [FIELD_W-1:0] p;
        m = v - 12'd1;
        p = 12'd1;
        if (v > 12'd1) begin
            for (int i = 0; i < FIELD_W - 1; i++) begin
                if (m[i]) begin
                    p = 12'd1 << (i + 1);
                end
            end
        end
        return p;
    endfunction

endpackage

/* rtl/shelf_rect_packer_top.sv */
// Shelf rectangle packer: places frames into an atlas by next-fit shelf packing.
//
// The block takes one command per transfer on the s_ channel and returns exactly one result per
// command on the m_ channel. A command moves into an input register, the placement logic works on
// it and the register file of shelf cursors combinationally, and the result lands in an output
// register; a new command can therefore be accepted in every cycle while m_ready is held high.
// Back-pressure on m_ channel stalls the input register once the output register is full.
// Configuration writes take effect in the cycle after the transfer and must only be made while
// no command is in flight.
module shelf_rect_packer_top
    import srp_pkg::*;
#(
    parameter int unsigned MAX_ATLAS_HEIGHT = MAX_ATLAS_HEIGHT_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_operation,
    input  logic [FIELD_W-1:0]     s_frame_width,
    input  logic [FIELD_W-1:0]     s_frame_height,
    input  logic [1:0]             s_frame_mode,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [POS_W-1:0]       m_pos_x,
    output logic [POS_W-1:0]       m_pos_y,
    output logic [1:0]             m_status,
    output logic [FIELD_W-1:0]     m_used_width,
    output logic [FIELD_W-1:0]     m_used_height
);

    localparam int unsigned HW = $clog2(MAX_ATLAS_HEIGHT + 1);
    localparam int unsigned SW = ((HW > FIELD_W) ? HW : FIELD_W) + 1;

    logic [FIELD_W-1:0] atlas_width_reg, atlas_width_next;
    logic               packing_mode_reg, packing_mode_next;

    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [FIELD_W-1:0] in_fw_reg;
    logic [FIELD_W-1:0] in_fh_reg;
    logic [1:0]         in_fm_reg;

    logic [HW-1:0]      top_reg [2];
    logic [HW-1:0]      top_next [2];
    logic [FIELD_W-1:0] cursor_reg [2];
    logic [FIELD_W-1:0] cursor_next [2];
    logic [HW-1:0]      next_top_reg [2];
    logic [HW-1:0]      next_top_next [2];
    logic [FIELD_W-1:0] widest_reg [2];
    logic [FIELD_W-1:0] widest_next [2];
    logic               shared_reg, shared_next;
    logic [1:0]         err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [1:0]         status_reg, status_next;
    logic [FIELD_W-1:0] used_w_reg, used_w_next;
    logic [FIELD_W-1:0] used_h_reg, used_h_next;

    logic               advance;
    logic [FIELD_W-1:0] aw;
    logic               place_ok;
    logic               sel;
    logic [FIELD_W:0]   cur_sum;
    logic               wrap;
    logic [FIELD_W-1:0] cur_eff;
    logic [HW-1:0]      top_eff;
    logic [SW-1:0]      bottom;
    logic               fail;
    logic [FIELD_W-1:0] cur_new;
    logic [HW-1:0]      nt_new;
    logic [FIELD_W-1:0] wid_new;
    logic [HW-1:0]      max_nt;
    logic [SW-1:0]      max_nt_ext;
    logic [FIELD_W-1:0] max_wid;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid       = out_valid_reg;
    assign m_pos_x       = pos_x_reg;
    assign m_pos_y       = pos_y_reg;
    assign m_status      = status_reg;
    assign m_used_width  = used_w_reg;
    assign m_used_height = used_h_reg;

    assign aw = (atlas_width_reg > ATLAS_WIDTH_LIMIT) ? ATLAS_WIDTH_LIMIT : atlas_width_reg;

    always_comb begin
        atlas_width_next  = atlas_width_reg;
        packing_mode_next = packing_mode_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ATLAS_WIDTH:  atlas_width_next  = cfg_data;
                CFG_PACKING_MODE: packing_mode_next = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        sel      = 1'b0;
        place_ok = 1'b1;
        if (packing_mode_reg == PM_SPLIT) begin
            priority if (in_fm_reg == FM_RGB) begin
                sel = 1'b0;
            end else if (in_fm_reg == FM_ALPHA) begin
                sel = 1'b1;
            end else if (in_fm_reg == FM_RGBA && shared_reg) begin
                sel = 1'b0;
            end else begin
                place_ok = 1'b0;
            end
        end
    end

    always_comb begin
        cur_sum = {1'b0, cursor_reg[sel]} + {1'b0, in_fw_reg};
        wrap    = cur_sum > {1'b0, aw};
        cur_eff = wrap ? '0 : cursor_reg[sel];
        top_eff = wrap ? next_top_reg[sel] : top_reg[sel];
        bottom  = {{(SW-HW){1'b0}}, top_eff} + {{(SW-FIELD_W){1'b0}}, in_fh_reg};
        fail    = (wrap && (in_fw_reg > aw)) || (bottom > SW'(MAX_ATLAS_HEIGHT));
        cur_new = wrap ? in_fw_reg : cur_sum[FIELD_W-1:0];
        nt_new  = (bottom[HW-1:0] > next_top_reg[sel]) ? bottom[HW-1:0] : next_top_reg[sel];
        wid_new = (cur_new > widest_reg[sel]) ? cur_new : widest_reg[sel];
    end

    always_comb begin
        max_nt     = (next_top_reg[0] > next_top_reg[1]) ? next_top_reg[0] : next_top_reg[1];
        max_nt_ext = {{(SW-HW){1'b0}}, max_nt};
        max_wid    = (widest_reg[0] > widest_reg[1]) ? widest_reg[0] : widest_reg[1];
    end

    always_comb begin
        top_next      = top_reg;
        cursor_next   = cursor_reg;
        next_top_next = next_top_reg;
        widest_next   = widest_reg;
        shared_next   = shared_reg;
        err_next      = err_reg;
        pos_x_next    = '0;
        pos_y_next    = '0;
        used_w_next   = '0;
        used_h_next   = '0;

        unique case (in_op_reg)
            OP_START: begin
                top_next      = '{default: '0};
                cursor_next   = '{default: '0};
                next_top_next = '{default: '0};
                widest_next   = '{default: '0};
                shared_next   = 1'b1;
                err_next      = ST_OK;
            end
            OP_PLACE: begin
                if (err_reg == ST_OK) begin
                    if (packing_mode_reg == PM_SPLIT &&
                        (in_fm_reg == FM_RGB || in_fm_reg == FM_ALPHA)) begin
                        shared_next = 1'b0;
                    end
                    if (!place_ok) begin
                        err_next = ST_ORDER;
                    end else begin
                        top_next[sel]    = top_eff;
                        cursor_next[sel] = cur_eff;
                        if (fail) begin
                            err_next = ST_NOFIT;
                        end else begin
                            pos_x_next         = cur_eff[POS_W-1:0];
                            pos_y_next         = POS_W'(top_eff);
                            cursor_next[sel]   = cur_new;
                            next_top_next[sel] = nt_new;
                            widest_next[sel]   = wid_new;
                            if (shared_next) begin
                                top_next[1]      = top_eff;
                                cursor_next[1]   = cur_new;
                                next_top_next[1] = nt_new;
                                widest_next[1]   = wid_new;
                            end
                        end
                    end
                end
            end
            OP_FINISH: begin
                used_w_next = pow2_ceil(max_wid);
                used_h_next = (max_nt_ext > SW'(ATLAS_WIDTH_LIMIT)) ? USED_SIZE_CLAMP
                                                                    : pow2_ceil(max_nt_ext[FIELD_W-1:0]);
            end
            default: ;
        endcase

        status_next = err_next;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_width_reg  <= ATLAS_WIDTH_LIMIT;
            packing_mode_reg <= PM_FLAT;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            top_reg          <= '{default: '0};
            cursor_reg       <= '{default: '0};
            next_top_reg     <= '{default: '0};
            widest_reg       <= '{default: '0};
            shared_reg       <= 1'b1;
            err_reg          <= ST_OK;
        end else begin
            atlas_width_reg  <= atlas_width_next;
            packing_mode_reg <= packing_mode_next;
            out_valid_reg    <= out_valid_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                top_reg      <= top_next;
                cursor_reg   <= cursor_next;
                next_top_reg <= next_top_next;
                widest_reg   <= widest_next;
                shared_reg   <= shared_next;
                err_reg      <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg <= s_operation;
            in_fw_reg <= s_frame_width;
            in_fh_reg <= s_frame_height;
            in_fm_reg <= s_frame_mode;
        end
        if (advance) begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            status_reg <= status_next;
            used_w_reg <= used_w_next;
            used_h_reg <= used_h_next;
        end
    end

endmodule

/* rtl/srp_checker.sv */
// Port-level assertion checker for the shelf packer, bound to the top level.
`include "shelf_rect_packer_top_macros.svh"

module srp_checker
    import srp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [POS_W-1:0]   m_pos_x,
    input logic [POS_W-1:0]   m_pos_y,
    input logic [1:0]         m_status,
    input logic [FIELD_W-1:0] m_used_width,
    input logic [FIELD_W-1:0] m_used_height
);

    // A stalled result must hold until its transfer.
    `SRP_ASSERT_NEXT(a_result_held, m_valid && !m_ready,
        m_valid && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_status) &&
        $stable(m_used_width) && $stable(m_used_height),
        "result changed while stalled")

    // The input side only stalls when a result is waiting and not taken.
    `SRP_ASSERT_NOW(a_stall_cause, !s_ready, m_valid && !m_ready,
        "input stalled without output back-pressure")

    // A failed or rejected placement never reports a position.
    `SRP_ASSERT_NOW(a_no_pos_on_error, m_valid && m_status != ST_OK,
        m_pos_x == '0 && m_pos_y == '0, "position reported with error status")

    // Reported sizes are zero, a power of two or the clamp value.
    `SRP_ASSERT_NOW(a_size_pow2, m_valid,
        ($onehot0(m_used_width) || m_used_width == USED_SIZE_CLAMP) &&
        ($onehot0(m_used_height) || m_used_height == USED_SIZE_CLAMP),
        "used size is not a power of two")

endmodule

bind shelf_rect_packer_top srp_checker u_srp_checker (.*);
